FILE: hdl/athr_pkg.sv
package athr_pkg;

  localparam int CHAN_W   = 2;
  localparam int SAMPLE_W = 10;
  localparam int THR_W    = 40;
  localparam int DEF_W    = 4;
  localparam int SEL_W    = 16;
  localparam int DIR_W    = 16;
  localparam int NUM_W    = 4;
  localparam int ADDR_W   = 6;
  localparam int DATA_W   = 64;
  localparam int REG_IDX_W = 3;
  localparam int REG_LSB  = 3;

  localparam logic [REG_IDX_W-1:0] REG_HIGH_THR = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOW_THR  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DEF_LVL  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OUT_SEL  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RLY_SEL  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_IO_DIR   = 3'd5;

  typedef struct packed {
    logic [THR_W-1:0] high_thr;
    logic [THR_W-1:0] low_thr;
    logic [DEF_W-1:0] def_lvl;
    logic [SEL_W-1:0] out_sel;
    logic [SEL_W-1:0] rly_sel;
    logic [DIR_W-1:0] io_dir;
  } cfg_t;

  typedef struct packed {
    logic              event_res;
    logic [CHAN_W-1:0] event_channel;
    logic              crossed_high;
    logic              drive_output;
    logic [NUM_W-1:0]  output_number;
    logic              output_level;
    logic              drive_relay;
    logic [NUM_W-1:0]  relay_number;
    logic              relay_level;
    logic              notify;
  } res_t;

endpackage

FILE: hdl/athr_cfg.sv
module athr_cfg import athr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t                 cfg_q;
  cfg_t                 cfg_d;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:REG_LSB];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_HIGH_THR: cfg_d.high_thr = pwdata[THR_W-1:0];
        REG_LOW_THR:  cfg_d.low_thr  = pwdata[THR_W-1:0];
        REG_DEF_LVL:  cfg_d.def_lvl  = pwdata[DEF_W-1:0];
        REG_OUT_SEL:  cfg_d.out_sel  = pwdata[SEL_W-1:0];
        REG_RLY_SEL:  cfg_d.rly_sel  = pwdata[SEL_W-1:0];
        REG_IO_DIR:   cfg_d.io_dir   = pwdata[DIR_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HIGH_THR: prdata = DATA_W'(cfg_q.high_thr);
      REG_LOW_THR:  prdata = DATA_W'(cfg_q.low_thr);
      REG_DEF_LVL:  prdata = DATA_W'(cfg_q.def_lvl);
      REG_OUT_SEL:  prdata = DATA_W'(cfg_q.out_sel);
      REG_RLY_SEL:  prdata = DATA_W'(cfg_q.rly_sel);
      REG_IO_DIR:   prdata = DATA_W'(cfg_q.io_dir);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_thr <= '1;
      cfg_q.low_thr  <= '0;
      cfg_q.def_lvl  <= '0;
      cfg_q.out_sel  <= '0;
      cfg_q.rly_sel  <= '0;
      cfg_q.io_dir   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/athr_eval.sv
module athr_eval import athr_pkg::*; #(
  parameter int CHANNELS    = 4,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic [CHAN_W-1:0]   channel_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  cfg_t                cfg_i,
  output res_t                res_o
);

  localparam int MAX_CH   = 1 << CHAN_W;
  localparam int LATCHES  = (CHANNELS < MAX_CH) ? CHANNELS : MAX_CH;
  localparam int USED_W   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int PACK_W   = (LATCHES * SAMPLE_BITS > THR_W) ? LATCHES * SAMPLE_BITS : THR_W;

  logic [LATCHES-1:0]                  above_q, above_d;
  logic [LATCHES-1:0]                  below_q, below_d;
  logic [LATCHES-1:0]                  sel;
  logic [PACK_W-1:0]                   hi_ext, lo_ext;
  logic [LATCHES-1:0][SAMPLE_BITS-1:0] thr_hi, thr_lo;
  logic [SAMPLE_BITS-1:0]              hi_thr, lo_thr, smp;
  logic                                chan_ok, above, below;
  logic                                hit_hi, hit_lo, ev, def, lvl, dout, drel;
  logic [NUM_W-1:0]                    onum, rnum;

  assign hi_ext = PACK_W'(cfg_i.high_thr);
  assign lo_ext = PACK_W'(cfg_i.low_thr);
  assign smp    = SAMPLE_BITS'(sample_i[USED_W-1:0]);

  always_comb begin
    hi_thr = '0;
    lo_thr = '0;
    for (int i = 0; i < LATCHES; i++) begin
      sel[i]    = (32'(channel_i) == i);
      thr_hi[i] = hi_ext[i*SAMPLE_BITS +: SAMPLE_BITS];
      thr_lo[i] = lo_ext[i*SAMPLE_BITS +: SAMPLE_BITS];
      hi_thr    = hi_thr | (sel[i] ? thr_hi[i] : '0);
      lo_thr    = lo_thr | (sel[i] ? thr_lo[i] : '0);
    end
  end

  assign chan_ok = |sel;
  assign above   = |(sel & above_q);
  assign below   = |(sel & below_q);
  assign hit_hi  = chan_ok && (smp > hi_thr) && !above;
  assign hit_lo  = chan_ok && !hit_hi && (smp < lo_thr) && !below;
  assign ev      = hit_hi || hit_lo;

  assign def  = cfg_i.def_lvl[channel_i];
  assign lvl  = hit_hi ? def : !def;
  assign onum = cfg_i.out_sel[{channel_i, 2'b00} +: NUM_W];
  assign rnum = cfg_i.rly_sel[{channel_i, 2'b00} +: NUM_W];
  assign dout = ev && (onum != '0) && cfg_i.io_dir[onum];
  assign drel = ev && (rnum != '0);

  always_comb begin
    res_o               = '0;
    res_o.event_channel = channel_i;
    res_o.event_res     = ev;
    res_o.crossed_high  = hit_hi;
    res_o.drive_output  = dout;
    res_o.output_number = dout ? onum : '0;
    res_o.output_level  = dout && lvl;
    res_o.drive_relay   = drel;
    res_o.relay_number  = drel ? rnum : '0;
    res_o.relay_level   = drel && lvl;
    res_o.notify        = dout || drel;
  end

  always_comb begin
    above_d = above_q;
    below_d = below_q;
    if (hit_hi) begin
      above_d = above_q | sel;
      below_d = below_q & ~sel;
    end else if (hit_lo) begin
      below_d = below_q | sel;
      above_d = above_q & ~sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q <= '0;
      below_q <= '0;
    end else if (adv_i) begin
      above_q <= above_d;
      below_q <= below_d;
    end
  end

  a_latch_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (above_q & below_q) == '0)
    else $error("channel has both latches set");

  a_hi_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_o.event_res && res_o.crossed_high |=> (above_q & $past(sel)) != '0)
    else $error("high crossing did not set above latch");

  a_lo_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_o.event_res && !res_o.crossed_high |=> (below_q & $past(sel)) != '0)
    else $error("low crossing did not set below latch");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(above_q) && $stable(below_q))
    else $error("latches changed without a transaction");

endmodule

FILE: hdl/analog_threshold_hysteresis_relay.sv
// Window comparator with hysteresis over the analog channels.
// Input channel: in_valid_i / in_stall_o carry one transaction of channel_i and
// sample_i. Output channel: out_valid_o / out_stall_i carry one result per
// transaction: crossing event, direction, and the output and relay to drive.
// Thresholds, levels and mappings sit in an APB register file, one register
// every 8 bytes, 64-bit data, pready tied high; write only while idle.
// Path: a transaction is held in the input register, is evaluated
// against the per-channel latches and lands in the result register, from
// which it leaves when the output is not stalled.
// Throughput: one transaction per cycle while the output is not stalled, set
// by the single evaluate stage between the input and result registers.
// Reset clears both latches of every channel, empties both registers and
// loads the register defaults (high thresholds all ones, the rest zero).
// A stall on the output holds the result; the input register keeps
// accepting until it is full, then in_stall_o rises in the same cycle.
module analog_threshold_hysteresis_relay import athr_pkg::*; #(
  parameter int CHANNELS    = 4,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CHAN_W-1:0]   channel_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                event_res_o,
  output logic [CHAN_W-1:0]   event_channel_o,
  output logic                crossed_high_o,
  output logic                drive_output_o,
  output logic [NUM_W-1:0]    output_number_o,
  output logic                output_level_o,
  output logic                drive_relay_o,
  output logic [NUM_W-1:0]    relay_number_o,
  output logic                relay_level_o,
  output logic                notify_o
);

  cfg_t                cfg;
  res_t                res;
  res_t                res_q;
  logic                in_valid_q, in_valid_d;
  logic                out_valid_q, out_valid_d;
  logic [CHAN_W-1:0]   channel_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                res_ready, adv, accept;

  athr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  athr_eval #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .channel_i (channel_q),
    .sample_i  (sample_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  assign res_ready  = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && res_ready;
  assign in_stall_o = in_valid_q && !res_ready;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_valid_d  = accept || (in_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      channel_q <= channel_i;
      sample_q  <= sample_i;
    end
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = res_q.event_res;
  assign event_channel_o = res_q.event_channel;
  assign crossed_high_o  = res_q.crossed_high;
  assign drive_output_o  = res_q.drive_output;
  assign output_number_o = res_q.output_number;
  assign output_level_o  = res_q.output_level;
  assign drive_relay_o   = res_q.drive_relay;
  assign relay_number_o  = res_q.relay_number;
  assign relay_level_o   = res_q.relay_level;
  assign notify_o        = res_q.notify;

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q)
    else $error("stalled result dropped");

  a_adv_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q && (res_q == $past(res)))
    else $error("evaluated transaction not captured");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import athr_pkg::*;

  localparam int NUM_CH = 4;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

  class hysteresis_scoreboard;
    logic [THR_W-1:0] high_thr;
    logic [THR_W-1:0] low_thr;
    logic [DEF_W-1:0] def_lvl;
    logic [SEL_W-1:0] out_sel;
    logic [SEL_W-1:0] rly_sel;
    logic [DIR_W-1:0] io_dir;
    bit               above[NUM_CH];
    bit               below[NUM_CH];
    res_t             relay_results_q[$];
    int               errors;

    function new();
      high_thr = '1;
      low_thr  = '0;
      def_lvl  = '0;
      out_sel  = '0;
      rly_sel  = '0;
      io_dir   = '0;
      errors   = 0;
      foreach (above[i]) begin
        above[i] = 1'b0;
        below[i] = 1'b0;
      end
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_HIGH_THR: high_thr = value[THR_W-1:0];
        REG_LOW_THR:  low_thr  = value[THR_W-1:0];
        REG_DEF_LVL:  def_lvl  = value[DEF_W-1:0];
        REG_OUT_SEL:  out_sel  = value[SEL_W-1:0];
        REG_RLY_SEL:  rly_sel  = value[SEL_W-1:0];
        REG_IO_DIR:   io_dir   = value[DIR_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_crossing(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] s);
      res_t              r;
      int                c;
      logic [SAMPLE_W-1:0] hi_t;
      logic [SAMPLE_W-1:0] lo_t;
      logic [NUM_W-1:0]  onum;
      logic [NUM_W-1:0]  rnum;
      logic              lvl;
      bit                hit;
      bit                up;
      r = '0;
      c = ch;
      hit = 1'b0;
      up = 1'b0;
      r.event_channel = ch;
      hi_t = high_thr[c*SAMPLE_W +: SAMPLE_W];
      lo_t = low_thr[c*SAMPLE_W +: SAMPLE_W];
      if (s > hi_t && !above[c]) begin
        above[c] = 1'b1;
        below[c] = 1'b0;
        hit = 1'b1;
        up = 1'b1;
      end else if (s < lo_t && !below[c]) begin
        below[c] = 1'b1;
        above[c] = 1'b0;
        hit = 1'b1;
      end
      if (hit) begin
        lvl  = up ? def_lvl[c] : !def_lvl[c];
        onum = out_sel[c*NUM_W +: NUM_W];
        rnum = rly_sel[c*NUM_W +: NUM_W];
        r.event_res = 1'b1;
        r.crossed_high = up;
        if (onum != 0 && io_dir[onum]) begin
          r.drive_output  = 1'b1;
          r.output_number = onum;
          r.output_level  = lvl;
        end
        if (rnum != 0) begin
          r.drive_relay  = 1'b1;
          r.relay_number = rnum;
          r.relay_level  = lvl;
        end
        r.notify = r.drive_output | r.drive_relay;
      end
      relay_results_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      if (relay_results_q.size() == 0) begin
        report("result with no transaction pending");
        return;
      end
      want = relay_results_q.pop_front();
      check_field("event_res", got.event_res, want.event_res);
      check_field("event_channel", got.event_channel, want.event_channel);
      check_field("crossed_high", got.crossed_high, want.crossed_high);
      check_field("drive_output", got.drive_output, want.drive_output);
      check_field("output_number", got.output_number, want.output_number);
      check_field("output_level", got.output_level, want.output_level);
      check_field("drive_relay", got.drive_relay, want.drive_relay);
      check_field("relay_number", got.relay_number, want.relay_number);
      check_field("relay_level", got.relay_level, want.relay_level);
      check_field("notify", got.notify, want.notify);
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CHAN_W-1:0]   channel_i = '0;
  logic [SAMPLE_W-1:0] sample_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                event_res_o;
  logic [CHAN_W-1:0]   event_channel_o;
  logic                crossed_high_o;
  logic                drive_output_o;
  logic [NUM_W-1:0]    output_number_o;
  logic                output_level_o;
  logic                drive_relay_o;
  logic [NUM_W-1:0]    relay_number_o;
  logic                relay_level_o;
  logic                notify_o;

  hysteresis_scoreboard sb;
  bit                   gaps_on = 1'b1;

  analog_threshold_hysteresis_relay dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .channel_i       (channel_i),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_res_o     (event_res_o),
    .event_channel_o (event_channel_o),
    .crossed_high_o  (crossed_high_o),
    .drive_output_o  (drive_output_o),
    .output_number_o (output_number_o),
    .output_level_o  (output_level_o),
    .drive_relay_o   (drive_relay_o),
    .relay_number_o  (relay_number_o),
    .relay_level_o   (relay_level_o),
    .notify_o        (notify_o)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    res_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.event_res     = event_res_o;
        got.event_channel = event_channel_o;
        got.crossed_high  = crossed_high_o;
        got.drive_output  = drive_output_o;
        got.output_number = output_number_o;
        got.output_level  = output_level_o;
        got.drive_relay   = drive_relay_o;
        got.relay_number  = relay_number_o;
        got.relay_level   = relay_level_o;
        got.notify        = notify_o;
        sb.check_result(got);
      end
      out_stall_i <= gaps_on && ($urandom_range(99) < 18);
    end
  end

  task automatic write_config(logic [THR_W-1:0] hi, logic [THR_W-1:0] lo,
                              logic [DEF_W-1:0] dl, logic [SEL_W-1:0] os,
                              logic [SEL_W-1:0] rs, logic [DIR_W-1:0] dir);
    logic [DATA_W-1:0]    vals[6];
    logic [REG_IDX_W-1:0] idxs[6];
    idxs = '{REG_HIGH_THR, REG_LOW_THR, REG_DEF_LVL, REG_OUT_SEL, REG_RLY_SEL, REG_IO_DIR};
    vals[0] = {24'($urandom), hi};
    vals[1] = {24'($urandom), lo};
    vals[2] = {32'($urandom), 28'($urandom), dl};
    vals[3] = {32'($urandom), 16'($urandom), os};
    vals[4] = {32'($urandom), 16'($urandom), rs};
    vals[5] = {32'($urandom), 16'($urandom), dir};
    for (int i = 0; i < 6; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(idxs[i]) << REG_LSB;
      pwdata  <= vals[i];
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      sb.set_reg(idxs[i], vals[i]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] s);
    while (gaps_on && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    sb.predict_crossing(ch, s);
  endtask

  // hold the sender until every result is back, then let the pipeline settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.relay_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(int c);
    int v;
    case ($urandom_range(9))
      0: v = 0;
      1: v = SAMPLE_MAX;
      2, 3: v = int'(sb.high_thr[c*SAMPLE_W +: SAMPLE_W]) + $urandom_range(2) - 1;
      4, 5: v = int'(sb.low_thr[c*SAMPLE_W +: SAMPLE_W]) + $urandom_range(2) - 1;
      default: v = $urandom_range(SAMPLE_MAX);
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  task automatic random_phase(int kind, int count);
    logic [THR_W-1:0] hi;
    logic [THR_W-1:0] lo;
    int               l;
    int               h;
    int               c;
    case (kind)
      0: write_config('0, '1, '1, '1, '1, '1);
      1: write_config('1, '0, '0, '0, '0, '0);
      default: begin
        for (int i = 0; i < NUM_CH; i++) begin
          l = $urandom_range(SAMPLE_MAX);
          h = l + $urandom_range(SAMPLE_MAX - l);
          if ($urandom_range(7) == 0) h = $urandom_range(SAMPLE_MAX);
          hi[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(h);
          lo[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(l);
        end
        write_config(hi, lo, DEF_W'($urandom), SEL_W'($urandom), SEL_W'($urandom),
                     DIR_W'($urandom));
      end
    endcase
    for (int n = 0; n < count; n++) begin
      c = $urandom_range(NUM_CH - 1);
      send_sample(CHAN_W'(c), pick_sample(c));
    end
    wait_drained();
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sample(2'd0, 10'd1023);
    send_sample(2'd3, 10'd0);
    wait_drained();

    // ch0 maps to a non-output pin, ch1 output and relay, ch2 relay only, ch3 output only
    write_config({10'd700, 10'd0, 10'd1022, 10'd512},
                 {10'd300, 10'd0, 10'd1, 10'd256},
                 4'b0101, 16'hF031, 16'h07F2, 16'h8009);
    send_sample(2'd0, 10'd600);
    send_sample(2'd0, 10'd600);
    send_sample(2'd0, 10'd300);
    send_sample(2'd0, 10'd100);
    send_sample(2'd0, 10'd100);
    send_sample(2'd0, 10'd1023);
    send_sample(2'd0, 10'd0);
    send_sample(2'd1, 10'd1023);
    send_sample(2'd1, 10'd1022);
    send_sample(2'd1, 10'd0);
    send_sample(2'd2, 10'd0);
    send_sample(2'd2, 10'd1);
    send_sample(2'd3, 10'd1023);
    send_sample(2'd3, 10'd0);
    send_sample(2'd3, 10'd700);
    wait_drained();

    // inverted window: high test wins, then the low latch takes over
    write_config({30'h3FFF_FFFF, 10'd100}, {30'd0, 10'd900},
                 4'b0001, 16'h0002, 16'h0009, 16'h0004);
    send_sample(2'd0, 10'd500);
    send_sample(2'd0, 10'd500);
    send_sample(2'd0, 10'd500);
    wait_drained();

    random_phase(0, 150);
    random_phase(1, 60);
    for (int k = 2; k < 7; k++) begin
      gaps_on = (k != 3);
      random_phase(k, 140);
    end
    gaps_on = 1'b1;

    wait_drained();
    if (sb.errors == 0 && sb.relay_results_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
